>>> hdl/bptc_pkg.sv
package bptc_pkg;

  localparam int unsigned DivW = 32;

  // register map
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  localparam logic [1:0] OssReset = 2'd3;

  // compensation constants
  localparam logic signed [31:0] B6Offset  = 32'sd4000;
  localparam logic signed [31:0] PolyC1    = 32'sd3038;
  localparam logic signed [31:0] PolyC2    = -32'sd7357;
  localparam logic signed [31:0] PolyC3    = 32'sd3791;
  localparam logic [31:0]        B7Scale   = 32'd50000;
  localparam logic signed [31:0] B4Offset  = 32'sd32768;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } coef_t;

  // sideband through the temperature divider
  typedef struct packed {
    logic [18:0]        up;
    logic signed [31:0] x1;
    logic               neg;
    logic               err_t;
  } tside_t;

  // sideband through the pressure divider
  typedef struct packed {
    logic signed [31:0] temp;
    logic               hi;
    logic               err_t;
    logic               err_p;
  } pside_t;

  // signed divide by 2^k, truncated toward zero
  function automatic logic signed [31:0] tdiv2(input logic signed [31:0] a,
                                                input int unsigned k);
    logic [31:0] bias;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return (a + signed'(bias)) >>> k;
  endfunction

endpackage

>>> hdl/bptc_udiv.sv
module bptc_udiv #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [SW-1:0] side_o
);

  // one quotient bit per stage, msb first
  logic          vld_q  [1:W];
  logic [W-1:0]  rem_q  [1:W];
  logic [W-1:0]  num_q  [1:W];
  logic [W-1:0]  den_q  [1:W];
  logic [W-1:0]  quo_q  [1:W];
  logic [SW-1:0] side_q [1:W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic          cur_vld;
    logic [W-1:0]  cur_rem;
    logic [W-1:0]  cur_num;
    logic [W-1:0]  cur_den;
    logic [W-1:0]  cur_quo;
    logic [SW-1:0] cur_side;
    logic [W:0]    trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign cur_vld  = valid_i;
      assign cur_rem  = '0;
      assign cur_num  = num_i;
      assign cur_den  = den_i;
      assign cur_quo  = '0;
      assign cur_side = side_i;
    end else begin : g_next
      assign cur_vld  = vld_q[s];
      assign cur_rem  = rem_q[s];
      assign cur_num  = num_q[s];
      assign cur_den  = den_q[s];
      assign cur_quo  = quo_q[s];
      assign cur_side = side_q[s];
    end

    assign trial = {cur_rem, cur_num[W-1]};
    assign ge    = trial >= {1'b0, cur_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? W'(trial - {1'b0, cur_den}) : trial[W-1:0];
        num_q[s+1]  <= cur_num << 1;
        den_q[s+1]  <= cur_den;
        quo_q[s+1]  <= {cur_quo[W-2:0], ge};
        side_q[s+1] <= cur_side;
      end
    end
  end

  assign valid_o = vld_q[W];
  assign quot_o  = quo_q[W];
  assign side_o  = side_q[W];

endmodule

>>> hdl/bptc_temp.sv
module bptc_temp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bptc_pkg::coef_t     coef_i,
  input  logic                valid_i,
  input  logic [15:0]         ut_i,
  input  logic [18:0]         up_i,
  output logic                valid_o,
  output logic [31:0]         num_o,
  output logic [31:0]         den_o,
  output bptc_pkg::tside_t    side_o
);
  import bptc_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] prod_q;
  logic [18:0]        up1_q, up2_q;
  logic signed [31:0] x1_q;
  logic signed [31:0] d_q;
  logic [31:0]        num_q, den_q;
  tside_t             side_q;

  logic signed [31:0] dif, prod_d, x1_d, d_d, numv;
  logic [31:0]        num_d, den_d;
  tside_t             side_d;

  always_comb begin
    dif    = signed'({16'b0, ut_i}) - signed'({16'b0, coef_i.ac6});
    prod_d = dif * signed'({16'b0, coef_i.ac5});
    x1_d   = tdiv2(prod_q, 15);
    d_d    = x1_d + 32'(coef_i.md);
    // mc * 2048 stays well inside 32 bits
    numv   = 32'(coef_i.mc) <<< 11;
    num_d  = numv[31] ? 32'(-numv) : 32'(numv);
    if (d_q == 32'sd0) begin
      den_d = 32'd1;
    end else begin
      den_d = d_q[31] ? 32'(-d_q) : 32'(d_q);
    end
    side_d.up    = up2_q;
    side_d.x1    = x1_q;
    side_d.neg   = numv[31] ^ d_q[31];
    side_d.err_t = (d_q == 32'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      up1_q  <= up_i;
      x1_q   <= x1_d;
      d_q    <= d_d;
      up2_q  <= up1_q;
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

>>> hdl/bptc_press.sv
module bptc_press (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bptc_pkg::coef_t     coef_i,
  input  logic                valid_i,
  input  logic [31:0]         quot_i,
  input  bptc_pkg::tside_t    side_i,
  output logic                valid_o,
  output logic [31:0]         num_o,
  output logic [31:0]         den_o,
  output bptc_pkg::pside_t    side_o
);
  import bptc_pkg::*;

  // valid chain for stages a..g
  logic [6:0] v_q;

  logic signed [31:0] temp_a_q, temp_b_q, temp_c_q, temp_d_q, temp_e_q, temp_f_q;
  logic               et_a_q, et_b_q, et_c_q, et_d_q, et_e_q, et_f_q;
  logic [18:0]        up_a_q, up_b_q, up_c_q, up_d_q, up_e_q;
  logic signed [31:0] b6_a_q;
  logic signed [31:0] sqp_b_q, p2_b_q, p3_b_q;
  logic signed [31:0] sq_c_q, x2a_c_q, x1c_c_q;
  logic signed [31:0] x2a_d_q, x1c_d_q, pb2_d_q, pb1_d_q;
  logic signed [31:0] b3_e_q, t_e_q;
  logic [31:0]        b4_f_q, b7_f_q;
  logic [31:0]        num_q, den_q;
  pside_t             side_q;

  logic signed [31:0] x2, b5, x1e, x3e, sh, x2b, x3b;
  logic [31:0]        shu;

  always_comb begin
    x2  = side_i.neg ? -signed'(quot_i) : signed'(quot_i);
    b5  = side_i.x1 + x2;
    x1e = tdiv2(pb2_d_q, 11);
    x3e = x1e + x2a_d_q;
    shu = 32'(32'(coef_i.ac1) * 32'sd4 + x3e) << coef_i.oss;
    sh  = signed'(shu);
    x2b = tdiv2(pb1_d_q, 16);
    x3b = tdiv2(x1c_d_q + x2b + 32'sd2, 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // a: finish temperature
      temp_a_q <= tdiv2(b5 + 32'sd8, 4);
      b6_a_q   <= b5 - B6Offset;
      et_a_q   <= side_i.err_t;
      up_a_q   <= side_i.up;
      // b: first products
      sqp_b_q  <= b6_a_q * b6_a_q;
      p2_b_q   <= 32'(coef_i.ac2) * b6_a_q;
      p3_b_q   <= 32'(coef_i.ac3) * b6_a_q;
      temp_b_q <= temp_a_q;
      et_b_q   <= et_a_q;
      up_b_q   <= up_a_q;
      // c
      sq_c_q   <= tdiv2(sqp_b_q, 12);
      x2a_c_q  <= tdiv2(p2_b_q, 11);
      x1c_c_q  <= tdiv2(p3_b_q, 13);
      temp_c_q <= temp_b_q;
      et_c_q   <= et_b_q;
      up_c_q   <= up_b_q;
      // d
      pb2_d_q  <= 32'(coef_i.b2) * sq_c_q;
      pb1_d_q  <= 32'(coef_i.b1) * sq_c_q;
      x2a_d_q  <= x2a_c_q;
      x1c_d_q  <= x1c_c_q;
      temp_d_q <= temp_c_q;
      et_d_q   <= et_c_q;
      up_d_q   <= up_c_q;
      // e: b3 and the b4 factor
      b3_e_q   <= tdiv2(sh + 32'sd2, 2);
      t_e_q    <= x3b + B4Offset;
      temp_e_q <= temp_d_q;
      et_e_q   <= et_d_q;
      up_e_q   <= up_d_q;
      // f: unsigned path
      b4_f_q   <= ({16'b0, coef_i.ac4} * 32'(t_e_q)) >> 15;
      b7_f_q   <= ({13'b0, up_e_q} - 32'(b3_e_q)) * (B7Scale >> coef_i.oss);
      temp_f_q <= temp_e_q;
      et_f_q   <= et_e_q;
      // g: divider operands, split on the top bit of b7
      num_q        <= b7_f_q[31] ? b7_f_q : (b7_f_q << 1);
      den_q        <= (b4_f_q == 32'd0) ? 32'd1 : b4_f_q;
      side_q.temp  <= temp_f_q;
      side_q.hi    <= b7_f_q[31];
      side_q.err_t <= et_f_q;
      side_q.err_p <= (b4_f_q == 32'd0);
    end
  end

  assign valid_o = v_q[6];
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

>>> hdl/bptc_poly.sv
module bptc_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         quot_i,
  input  bptc_pkg::pside_t    side_i,
  output logic                valid_o,
  output logic signed [27:0]  temp_o,
  output logic signed [31:0]  pres_o,
  output logic                err_o
);
  import bptc_pkg::*;

  logic [3:0]         v_q;
  logic signed [31:0] p1_q, p2_q, p3_q;
  logic signed [31:0] x1_1_q, x1sq_2_q, m2_2_q, x1b_3_q, x2_3_q;
  pside_t             s1_q, s2_q, s3_q;
  logic signed [27:0] temp_q;
  logic signed [31:0] pres_q;
  logic               err_q;

  logic signed [31:0] p_d, x1c, pres_d;

  always_comb begin
    p_d    = side_i.hi ? signed'(quot_i << 1) : signed'(quot_i);
    x1c    = tdiv2(x1b_3_q, 16);
    pres_d = p3_q + tdiv2(x1c + x2_3_q + PolyC3, 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q     <= p_d;
      x1_1_q   <= tdiv2(p_d, 8);
      s1_q     <= side_i;
      x1sq_2_q <= x1_1_q * x1_1_q;
      m2_2_q   <= PolyC2 * p1_q;
      p2_q     <= p1_q;
      s2_q     <= s1_q;
      x1b_3_q  <= x1sq_2_q * PolyC1;
      x2_3_q   <= tdiv2(m2_2_q, 16);
      p3_q     <= p2_q;
      s3_q     <= s2_q;
      temp_q   <= s3_q.err_t ? 28'sd0 : s3_q.temp[27:0];
      pres_q   <= (s3_q.err_t || s3_q.err_p) ? 32'sd0 : pres_d;
      err_q    <= s3_q.err_t || s3_q.err_p;
    end
  end

  assign valid_o = v_q[3];
  assign temp_o  = temp_q;
  assign pres_o  = pres_q;
  assign err_o   = err_q;

endmodule

>>> hdl/baro_pressure_temp_compensation.sv
// Integer temperature and pressure compensation for a barometric sensor. Each beat carries
// one raw temperature and one raw pressure reading and yields one beat with temperature in
// 0.1 degC, pressure in Pa and a divide error flag (pressure zeroed on any zero divisor, temperature on
// a zero temperature divisor). Two 32-stage dividers (temperature x2 term and pressure b7/b4)
// plus 14 arithmetic stages take a new beat every cycle unless stall freezes the whole pipeline.
// The user must write coefficients and oversampling through cfg_* while idle; the block does not enforce it.
module baro_pressure_temp_compensation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [15:0]         ut_raw_i,
  input  logic [18:0]         up_raw_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [27:0]  temperature_tenths_o,
  output logic signed [31:0]  pressure_pa_o,
  output logic                divide_error_o
);
  import bptc_pkg::*;

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  coef_t       coef;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= OssReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AC1_AC2: ac12_q <= cfg_data_i;
        REG_AC3_AC4: ac34_q <= cfg_data_i;
        REG_AC5_AC6: ac56_q <= cfg_data_i;
        REG_B1_B2:   b12_q  <= cfg_data_i;
        REG_MC_MD:   mcmd_q <= cfg_data_i;
        REG_OSS:     oss_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.ac1 = signed'(ac12_q[31:16]);
    coef.ac2 = signed'(ac12_q[15:0]);
    coef.ac3 = signed'(ac34_q[31:16]);
    coef.ac4 = ac34_q[15:0];
    coef.ac5 = ac56_q[31:16];
    coef.ac6 = ac56_q[15:0];
    coef.b1  = signed'(b12_q[31:16]);
    coef.b2  = signed'(b12_q[15:0]);
    coef.mc  = signed'(mcmd_q[31:16]);
    coef.md  = signed'(mcmd_q[15:0]);
    coef.oss = oss_q;
  end

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  logic        t_vld;
  logic [31:0] t_num, t_den;
  tside_t      t_side;
  logic        td_vld;
  logic [31:0] td_quot;
  logic [$bits(tside_t)-1:0] td_side;
  logic        p_vld;
  logic [31:0] p_num, p_den;
  pside_t      p_side;
  logic        pd_vld;
  logic [31:0] pd_quot;
  logic [$bits(pside_t)-1:0] pd_side;

  bptc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .coef_i(coef),
    .valid_i, .ut_i(ut_raw_i), .up_i(up_raw_i),
    .valid_o(t_vld), .num_o(t_num), .den_o(t_den), .side_o(t_side)
  );

  bptc_udiv #(.W(DivW), .SW($bits(tside_t))) u_tdiv (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(t_vld), .num_i(t_num), .den_i(t_den), .side_i(t_side),
    .valid_o(td_vld), .quot_o(td_quot), .side_o(td_side)
  );

  bptc_press u_press (
    .clk_i, .rst_ni, .en_i(en), .coef_i(coef),
    .valid_i(td_vld), .quot_i(td_quot), .side_i(tside_t'(td_side)),
    .valid_o(p_vld), .num_o(p_num), .den_o(p_den), .side_o(p_side)
  );

  bptc_udiv #(.W(DivW), .SW($bits(pside_t))) u_pdiv (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(p_vld), .num_i(p_num), .den_i(p_den), .side_i(p_side),
    .valid_o(pd_vld), .quot_o(pd_quot), .side_o(pd_side)
  );

  bptc_poly u_poly (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(pd_vld), .quot_i(pd_quot), .side_i(pside_t'(pd_side)),
    .valid_o, .temp_o(temperature_tenths_o), .pres_o(pressure_pa_o),
    .err_o(divide_error_o)
  );

endmodule

>>> hdl/bptc_checker.sv
module bptc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                stall_o,
  input logic                valid_o,
  input logic                stall_i,
  input logic signed [27:0]  temperature_tenths_o,
  input logic signed [31:0]  pressure_pa_o,
  input logic                divide_error_o
);

  // held output beat keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(pressure_pa_o)
      && $stable(temperature_tenths_o) && $stable(divide_error_o))
    else $error("stalled output beat changed");

  // input side stalls only behind a stalled output beat
  a_stall: assert property (@(posedge clk_i)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output backpressure");

  // divide error zeroes the pressure
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && divide_error_o |-> pressure_pa_o == 32'sd0)
    else $error("pressure not zero on divide error");

  a_rst: assert property (@(posedge clk_i)
    !rst_ni |-> !valid_o)
    else $error("output valid during reset");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (.*);

>>> verif/tb_baro_pressure_temp_compensation.sv
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensation;
  import bptc_pkg::*;

  localparam int LATENCY = 78;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
  } reading_t;

  typedef struct packed {
    logic signed [27:0] temp;
    logic signed [31:0] pres;
    logic               err;
  } comp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [15:0] ut_raw_i = '0;
  logic [18:0] up_raw_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic signed [27:0] temperature_tenths_o;
  logic signed [31:0] pressure_pa_o;
  logic        divide_error_o;

  always #5 clk_i = ~clk_i;

  baro_pressure_temp_compensation u_top (.*);

  // predictor copy of the coefficient registers
  logic [31:0] m_ac12, m_ac34, m_ac56, m_b12, m_mcmd;
  logic [1:0]  m_oss;

  reading_t pending_q[$];
  comp_t    comp_q[$];
  int       mismatches = 0;
  int       beats_in = 0, beats_out = 0, err_beats = 0;
  int       settings_run = 0;
  bit       hold_sender = 1'b0;

  function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    if (b == -32'sd1) return 32'sd0 - a;
    return a / b;
  endfunction

  function automatic comp_t compensate(input reading_t r);
    logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut, up;
    logic signed [31:0] x1, x2, x3, b5, b6, b3, sq, p, d, t, pr;
    logic [31:0] ac4, b4, b7;
    comp_t c;
    ac1 = 32'(signed'(m_ac12[31:16])); ac2 = 32'(signed'(m_ac12[15:0]));
    ac3 = 32'(signed'(m_ac34[31:16])); ac4 = {16'd0, m_ac34[15:0]};
    ac5 = {16'd0, m_ac56[31:16]};      ac6 = {16'd0, m_ac56[15:0]};
    b1 = 32'(signed'(m_b12[31:16]));   b2 = 32'(signed'(m_b12[15:0]));
    mc = 32'(signed'(m_mcmd[31:16]));  md = 32'(signed'(m_mcmd[15:0]));
    ut = {16'd0, r.ut}; up = {13'd0, r.up};
    t = 0; pr = 0; c.err = 1'b0;
    x1 = tdiv((ut - ac6) * ac5, 32768);
    d = x1 + md;
    if (d == 0) begin
      c.err = 1'b1;
    end else begin
      x2 = tdiv(mc * 2048, d);
      b5 = x1 + x2;
      t = tdiv(b5 + 8, 16);
      b6 = b5 - 4000;
      sq = tdiv(b6 * b6, 4096);
      x1 = tdiv(b2 * sq, 2048);
      x2 = tdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = tdiv(signed'((ac1 * 4 + x3) << m_oss) + 2, 4);
      x1 = tdiv(ac3 * b6, 8192);
      x2 = tdiv(b1 * sq, 65536);
      x3 = tdiv(x1 + x2 + 2, 4);
      b4 = (ac4 * unsigned'(x3 + 32768)) / 32'd32768;
      b7 = unsigned'(up - b3) * (32'd50000 >> m_oss);
      if (b4 == 0) begin
        c.err = 1'b1;
      end else begin
        if (!b7[31]) p = signed'((b7 * 2) / b4);
        else p = signed'((b7 / b4) * 2);
        x1 = tdiv(p, 256);
        x1 = x1 * x1;
        x1 = tdiv(x1 * 3038, 65536);
        x2 = tdiv(-32'sd7357 * p, 65536);
        pr = p + tdiv(x1 + x2 + 3791, 16);
      end
    end
    c.temp = t[27:0];
    c.pres = pr;
    return c;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        comp_q.push_back(compensate({ut_raw_i, up_raw_i}));
        beats_in++;
        send_gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!valid_i || !stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          valid_i <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_sender) begin
          reading_t r;
          r = pending_q.pop_front();
          valid_i  <= 1'b1;
          ut_raw_i <= r.ut;
          up_raw_i <= r.up;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        beats_out++;
        if (divide_error_o) err_beats++;
        if (comp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          comp_t e;
          e = comp_q.pop_front();
          if (e.temp !== temperature_tenths_o || e.pres !== pressure_pa_o ||
              e.err !== divide_error_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp t=%0d p=%0d e=%0b got t=%0d p=%0d e=%0b",
                       e.temp, e.pres, e.err, temperature_tenths_o, pressure_pa_o,
                       divide_error_o);
          end
        end
        stall_left = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || cfg_we_i ||
        (pending_q.size() == 0 && comp_q.size() == 0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", comp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_q.size() == 0 && !valid_i && comp_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_AC1_AC2: m_ac12 = val;
      REG_AC3_AC4: m_ac34 = val;
      REG_AC5_AC6: m_ac56 = val;
      REG_B1_B2:   m_b12  = val;
      REG_MC_MD:   m_mcmd = val;
      REG_OSS:     m_oss  = val[1:0];
      default: ;
    endcase
  endtask

  task automatic load_coefs(input logic [31:0] a, b, c, d, e, input logic [31:0] o);
    write_reg(REG_AC1_AC2, a);
    write_reg(REG_AC3_AC4, b);
    write_reg(REG_AC5_AC6, c);
    write_reg(REG_B1_B2, d);
    write_reg(REG_MC_MD, e);
    write_reg(REG_OSS, o);
    settings_run++;
  endtask

  function automatic reading_t rand_reading();
    reading_t r;
    r.ut = 16'($urandom);
    r.up = 19'($urandom);
    case ($urandom_range(0, 5))
      0: r.ut = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: r.up = $urandom_range(0, 1) ? 19'h7FFFF : 19'h00000;
      2: begin r.ut = 16'(20000 + $urandom_range(0, 15000));
         r.up = 19'(20000 + $urandom_range(0, 60000)); end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    m_ac12 = 0; m_ac34 = 0; m_ac56 = 0; m_b12 = 0; m_mcmd = 0; m_oss = OssReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: md = 0 gives a temperature divide error
    pending_q.push_back('{16'd27898, 19'd23843});
    pending_q.push_back('{16'hFFFF, 19'h7FFFF});
    drain();

    // datasheet-like calibration, directed extremes
    load_coefs({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 32'd0);
    pending_q.push_back('{16'd27898, 19'd23843});
    pending_q.push_back('{16'd0, 19'd0});
    pending_q.push_back('{16'hFFFF, 19'h7FFFF});
    pending_q.push_back('{16'hFFFF, 19'd0});
    pending_q.push_back('{16'd0, 19'h7FFFF});
    pending_q.push_back('{16'h5555, 19'h2AAAA});
    pending_q.push_back('{16'hAAAA, 19'h55555});
    drain();
    // ac4 zero gives a pressure divide error; temperature still computed
    write_reg(REG_AC3_AC4, {-16'sd14383, 16'd0});
    pending_q.push_back('{16'd27898, 19'd23843});
    pending_q.push_back('{16'd1000, 19'd500000});
    drain();
    // x1 + md = 0 with ac5 = 0 and md = 0
    load_coefs(32'h7FFF8000, 32'h8000FFFF, 32'h0000FFFF, 32'h80007FFF, 32'h7FFF0000,
               32'hFFFFFFFF);
    pending_q.push_back('{16'd1234, 19'd4321});
    drain();
    // md = -1, mc extreme: divide by minus one, wraps everywhere
    write_reg(REG_MC_MD, 32'h8000FFFF);
    write_reg(REG_AC5_AC6, 32'h00000000);
    pending_q.push_back('{16'd0, 19'd0});
    pending_q.push_back('{16'hFFFF, 19'h7FFFF});
    drain();
    load_coefs(32'hFFFFFFFF, 32'h7FFF7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80008000, 32'd2);
    for (int i = 0; i < 8; i++) pending_q.push_back(rand_reading());
    drain();

    // random phases, each with fresh coefficients
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0)
        load_coefs({16'd408 + 16'($urandom_range(0, 200)), 16'($urandom_range(0, 100))},
                   {-16'sd14383, 16'd32741 - 16'($urandom_range(0, 2000))},
                   {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                   {-16'sd8711, 16'd2868}, $urandom_range(0, 3));
      else
        load_coefs($urandom, $urandom, $urandom, $urandom,
                   ($urandom_range(0, 7) == 0) ? {16'($urandom), 16'd0} : $urandom,
                   $urandom);
      for (int i = 0; i < 110; i++) pending_q.push_back(rand_reading());
      if (ph == 4) begin
        // sender holds until every result of the first half has arrived
        wait (pending_q.size() < 55);
        hold_sender = 1'b1;
        wait (comp_q.size() == 0);
        hold_sender = 1'b0;
      end
      drain();
    end

    $display("%0d readings in, %0d results out (%0d flagged), %0d coefficient sets",
             beats_in, beats_out, err_beats, settings_run);
    if (mismatches == 0 && comp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, comp_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bptc_pkg.sv
hdl/bptc_udiv.sv
hdl/bptc_temp.sv
hdl/bptc_press.sv
hdl/bptc_poly.sv
hdl/baro_pressure_temp_compensation.sv
hdl/bptc_checker.sv
verif/tb_baro_pressure_temp_compensation.sv
